// ===== hdl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared types for the first-fit segment allocator: result codes, request
// modes and the command / status bundles between controller and datapath
// ----------------------------------------------------------------------------
package ffsa_pkg;

	// result codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ZERO      = 3'd4
	} status_t;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic capture;      // latch request fields
		logic ld_ptr_zero;  // start scan at entry 0
		logic ld_ptr_top;   // start shift at last live entry
		logic scan;         // ascending table walk
		logic shift;        // descending move-up of entries
		logic wr_init;      // write the reset segment into entry 0
		logic wr_free;      // clear used bit of picked entry
		logic wr_used;      // picked entry becomes used with request length
		logic wr_rem;       // insert free remainder after picked entry
		logic count_inc;    // one more live entry
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mode_free;    // latched request is a free
		logic size_zero;    // latched allocate size is zero
		logic hit;          // entry under check matches
		logic miss_end;     // last live entry checked without a match
		logic exact;        // picked length equals request size
		logic full;         // table holds the maximum number of entries
		logic shift_done;   // no shift read or write outstanding
	} ctl_sts_t;

endpackage

// ===== hdl/first_fit_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// first-fit allocator over an address-ordered segment table without merging
// ----------------------------------------------------------------------------
// sequence: a zero-size allocate skips the scan; otherwise the table is scanned from entry 0
//   up to the first match or through all live entries, and a split then moves the entries
//   after the picked entry up by one before the remainder and the picked entry are written
// throughput: one transaction at a time; the table walk sets the rate, and a new request
//   waits while a finished result cannot enter the result register
// reset: arst_n clears control state; the S_INIT state then writes the full-memory
//   segment into entry 0 before in_ready rises
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
	import ffsa_pkg::*;
#(
	parameter int MEM_BYTES    = 1024,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [$clog2(MEM_BYTES+1)-1:0]      request_size,
	input  logic [$clog2(MEM_BYTES)-1:0]        free_address,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          status,
	output logic [$clog2(MEM_BYTES)-1:0]        granted_address
);

	// address covers the memory, length must also hold the whole memory size
	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int SIZE_W = $clog2(MEM_BYTES + 1);
	// table index and live entry count (count can equal the table depth)
	localparam int IDX_W  = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

	ctl_cmd_t          cmd;
	ctl_sts_t          sts;
	logic [ADDR_W-1:0] pick_start;

	// sequencer: owns the handshakes and the result register, so a finished
	// result can wait on out_ready while the next transaction is taken
	ffsa_ctrl #(
		.ADDR_W(ADDR_W)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.granted_address (granted_address),
		.sts             (sts),
		.pick_start      (pick_start),
		.cmd             (cmd)
	);

	// table memory plus walk pointer: one read per cycle during a scan, one
	// read and one write per cycle while entries move up for a split
	ffsa_dp #(
		.MEM_BYTES    (MEM_BYTES),
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_W       (ADDR_W),
		.SIZE_W       (SIZE_W),
		.IDX_W        (IDX_W),
		.CNT_W        (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.request_size (request_size),
		.free_address (free_address),
		.cmd          (cmd),
		.sts          (sts),
		.pick_start   (pick_start)
	);

endmodule

// ===== hdl/ffsa_dp.sv =====
// ----------------------------------------------------------------------------
// ffsa_dp
// segment table memory, scan / shift pointer, pick registers and entry count
// ----------------------------------------------------------------------------
module ffsa_dp
	import ffsa_pkg::*;
#(
	parameter int MEM_BYTES    = 1024,
	parameter int MAX_SEGMENTS = 16,
	parameter int ADDR_W       = 10,
	parameter int SIZE_W       = 11,
	parameter int IDX_W        = 4,
	parameter int CNT_W        = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] free_address,
	input  ctl_cmd_t          cmd,
	output ctl_sts_t          sts,
	output logic [ADDR_W-1:0] pick_start
);

	localparam logic [SIZE_W-1:0] FULL_LEN = SIZE_W'(MEM_BYTES);
	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_SEGMENTS);

	// segment table
	logic [ADDR_W-1:0] mem_start [MAX_SEGMENTS];
	logic [SIZE_W-1:0] mem_len   [MAX_SEGMENTS];
	logic              mem_used  [MAX_SEGMENTS];

	// request
	logic              req_mode_q;
	logic [SIZE_W-1:0] req_size_q;
	logic [ADDR_W-1:0] req_addr_q;

	// walk pointer and read stage
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [ADDR_W-1:0] rd_start_s1;
	logic [SIZE_W-1:0] rd_len_s1;
	logic              rd_used_s1;

	// picked entry
	logic [IDX_W-1:0]  pick_q;
	logic [ADDR_W-1:0] pick_start_q;
	logic [SIZE_W-1:0] pick_len_q;

	logic              rd_en;
	logic              hit;
	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [ADDR_W-1:0] wd_start;
	logic [SIZE_W-1:0] wd_len;
	logic              wd_used;

	always_comb begin
		rd_en = 1'b0;
		if (cmd.scan) begin
			rd_en = (ptr_q < count_q);
		end else if (cmd.shift) begin
			rd_en = (ptr_q > CNT_W'(pick_q));
		end
	end

	always_comb begin
		if (req_mode_q == MODE_FREE) begin
			hit = pend_s1 && (rd_start_s1 == req_addr_q);
		end else begin
			hit = pend_s1 && !rd_used_s1 && (rd_len_s1 >= req_size_q);
		end
	end

	// write port select
	always_comb begin
		we       = 1'b0;
		wa       = pick_q;
		wd_start = pick_start_q;
		wd_len   = pick_len_q;
		wd_used  = 1'b0;
		priority if (cmd.wr_init) begin
			we       = 1'b1;
			wa       = '0;
			wd_start = '0;
			wd_len   = FULL_LEN;
		end else if (cmd.wr_free) begin
			we = 1'b1;
		end else if (cmd.wr_used) begin
			we      = 1'b1;
			wd_len  = req_size_q;
			wd_used = 1'b1;
		end else if (cmd.wr_rem) begin
			we       = 1'b1;
			wa       = pick_q + IDX_W'(1);
			wd_start = pick_start_q + req_size_q[ADDR_W-1:0];
			wd_len   = pick_len_q - req_size_q;
		end else if (cmd.shift && pend_s1) begin
			we       = 1'b1;
			wa       = idx_s1 + IDX_W'(1);
			wd_start = rd_start_s1;
			wd_len   = rd_len_s1;
			wd_used  = rd_used_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[wa] <= wd_start;
			mem_len[wa]   <= wd_len;
			mem_used[wa]  <= wd_used;
		end
		if (rd_en) begin
			rd_start_s1 <= mem_start[ptr_q[IDX_W-1:0]];
			rd_len_s1   <= mem_len[ptr_q[IDX_W-1:0]];
			rd_used_s1  <= mem_used[ptr_q[IDX_W-1:0]];
			idx_s1      <= ptr_q[IDX_W-1:0];
		end
		if (cmd.capture) begin
			req_mode_q <= mode;
			req_size_q <= request_size;
			req_addr_q <= free_address;
		end
		if (cmd.scan && hit) begin
			pick_q       <= idx_s1;
			pick_start_q <= rd_start_s1;
			pick_len_q   <= rd_len_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= CNT_W'(1);
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			priority if (cmd.ld_ptr_zero) begin
				ptr_q <= '0;
			end else if (cmd.ld_ptr_top) begin
				ptr_q <= count_q - CNT_W'(1);
			end else if (rd_en && cmd.scan) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end else if (rd_en && cmd.shift) begin
				ptr_q <= ptr_q - CNT_W'(1);
			end
			if (cmd.count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	assign sts.mode_free  = (req_mode_q == MODE_FREE);
	assign sts.size_zero  = (req_size_q == '0);
	assign sts.hit        = hit;
	assign sts.miss_end   = pend_s1 && !hit && ((CNT_W'(idx_s1) + CNT_W'(1)) == count_q);
	assign sts.exact      = (pick_len_q == req_size_q);
	assign sts.full       = (count_q >= MAX_CNT);
	assign sts.shift_done = !rd_en && !pend_s1;
	assign pick_start     = pick_start_q;

endmodule

// ===== hdl/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl
// request sequencer: scan, decide, shift and insert, then result register
// ----------------------------------------------------------------------------
module ffsa_ctrl
	import ffsa_pkg::*;
#(
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [ADDR_W-1:0] granted_address,
	input  ctl_sts_t          sts,
	input  logic [ADDR_W-1:0] pick_start,
	output ctl_cmd_t          cmd
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_START,
		S_SCAN,
		S_ACT,
		S_SHIFT,
		S_INS_REM,
		S_INS_PICK,
		S_DONE
	} state_t;

	state_t            state_q;
	status_t           code_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] granted_q;

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	always_comb begin
		cmd             = '0;
		cmd.capture     = (state_q == S_IDLE) && in_valid;
		cmd.wr_init     = (state_q == S_INIT);
		cmd.ld_ptr_zero = (state_q == S_START);
		cmd.scan        = (state_q == S_SCAN);
		cmd.shift       = (state_q == S_SHIFT);
		cmd.wr_rem      = (state_q == S_INS_REM);
		cmd.wr_used     = (state_q == S_INS_PICK);
		cmd.count_inc   = (state_q == S_INS_PICK);
		if (state_q == S_ACT) begin
			if (sts.mode_free) begin
				cmd.wr_free = 1'b1;
			end else if (sts.exact) begin
				cmd.wr_used = 1'b1;
			end else if (!sts.full) begin
				cmd.ld_ptr_top = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			granted_q   <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				status_q    <= code_q;
				granted_q   <= (code_q == ST_OK && !sts.mode_free) ? pick_start : '0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (!sts.mode_free && sts.size_zero) begin
						code_q  <= ST_ZERO;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.hit) begin
						state_q <= S_ACT;
					end else if (sts.miss_end) begin
						code_q  <= sts.mode_free ? ST_NOT_FOUND : ST_NO_FIT;
						state_q <= S_DONE;
					end
				end
				S_ACT: begin
					if (sts.mode_free || sts.exact) begin
						code_q  <= ST_OK;
						state_q <= S_DONE;
					end else if (sts.full) begin
						code_q  <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (sts.shift_done) begin
						state_q <= S_INS_REM;
					end
				end
				S_INS_REM: begin
					state_q <= S_INS_PICK;
				end
				S_INS_PICK: begin
					code_q  <= ST_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/ffsa_checker.sv =====
// ----------------------------------------------------------------------------
// ffsa_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
module ffsa_checker
	import ffsa_pkg::*;
#(
	parameter int ADDR_W = 10
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [ADDR_W-1:0] granted_address
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_address))
		else $error("result changed while stalled");

	// only defined result codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NO_FIT || status == ST_FULL ||
			status == ST_NOT_FOUND || status == ST_ZERO))
		else $error("undefined result code");

	// failed transactions return address zero
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_address == '0)
		else $error("address on failed transaction");

	// one transaction at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind first_fit_segment_allocator ffsa_checker #(
	.ADDR_W($bits(granted_address))
) u_ffsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.granted_address (granted_address)
);
